// ===== rtl/x86se_pkg.sv =====
// Shared types, opcode constants and helpers for the x86 subset execute block.
package x86se_pkg;

  // Defaults for top-level parameters
  localparam int unsigned MaxPrefixesDef = 4;
  localparam int unsigned WindowBytesDef = 16;
  localparam int unsigned QueueDepthDef  = 2;

  // Window positions are always addressed with 4 bits (at most 16 bytes)
  localparam int unsigned WinMax = 16;
  localparam int unsigned PosW   = 4;

  // Prefix bytes
  localparam logic [7:0] PfxOpSize = 8'h66;
  localparam logic [7:0] PfxAddr   = 8'h67;
  localparam logic [7:0] PfxRep    = 8'hf3;

  // Opcodes
  localparam logic [7:0] OpIncLo    = 8'h40;
  localparam logic [7:0] OpDecHi    = 8'h4f;
  localparam logic [7:0] OpNop      = 8'h90;
  localparam logic [7:0] OpMovLo    = 8'hb8;
  localparam logic [7:0] OpMovHi    = 8'hbf;
  localparam logic [7:0] OpJmpFar   = 8'hea;
  localparam logic [7:0] OpJmpShort = 8'heb;
  localparam logic [7:0] OpInt      = 8'hcd;
  localparam logic [7:0] OpInt3     = 8'hcc;
  localparam logic [7:0] OpFlagLo   = 8'hf8;
  localparam logic [7:0] OpFlagHi   = 8'hfd;

  localparam logic [7:0] Int3Vector = 8'd3;

  // Register file reset: stack pointer entry starts at 0xff0
  localparam logic [2:0]  SpIndex = 3'd4;
  localparam logic [31:0] SpReset = 32'h0000_0ff0;

  // Flag bit positions
  localparam int unsigned FlagCf = 0;
  localparam int unsigned FlagIf = 9;
  localparam int unsigned FlagDf = 10;

  // Flag instruction selector (opcode bits 2:1)
  localparam logic [1:0] FlagSelCf = 2'd0;
  localparam logic [1:0] FlagSelIf = 2'd1;

  typedef enum logic [3:0] {
    KindIncDec,
    KindNop,
    KindMov,
    KindInt,
    KindJmpFar,
    KindJmpShort,
    KindFlag,
    KindUnimpl,
    KindPfxErr
  } kind_e;

  typedef enum logic [1:0] {
    StatOk     = 2'd0,
    StatSwInt  = 2'd1,
    StatUnimpl = 2'd2,
    StatPrefix = 2'd3
  } status_e;

  // Decoded item passed from front to back
  typedef struct packed {
    kind_e       kind;
    logic        is16;
    logic [3:0]  op_lo;   // opcode bits 3:0 (reg index, inc/dec, flag select)
    logic [31:0] imm;     // mov imm, far offset, short rel (disp + len), int vector
    logic [15:0] seg;     // far jump segment
    logic [4:0]  len;
  } item_t;

  // Replace only the low half at 16-bit operand size
  function automatic logic [31:0] merge(input logic is16, input logic [31:0] oldv,
                                        input logic [31:0] newv);
    merge = is16 ? {oldv[31:16], newv[15:0]} : newv;
  endfunction

endpackage

// ===== rtl/x86se_decode.sv =====
// Front end: prefix scan, opcode classification and immediate extraction.
module x86se_decode #(
  parameter int unsigned MaxPrefixes = x86se_pkg::MaxPrefixesDef,
  parameter int unsigned WindowBytes = x86se_pkg::WindowBytesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [0:0]          cfg_data_i,
  input  logic [63:0]         instr_bytes_low_i,
  input  logic [63:0]         instr_bytes_high_i,
  output x86se_pkg::item_t    item_o
);

  localparam int unsigned PosW = x86se_pkg::PosW;

  // Default operand size register
  logic mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b1;
    end else if (cfg_we_i) begin
      mode_q <= cfg_data_i[0];
    end
  end

  // Window bytes, zero past the window end
  logic [127:0] full;
  logic [7:0]   win [x86se_pkg::WinMax];

  assign full = {instr_bytes_high_i, instr_bytes_low_i};

  always_comb begin
    for (int i = 0; i < x86se_pkg::WinMax; i++) begin
      win[i] = (i < WindowBytes) ? full[i*8 +: 8] : 8'h00;
    end
  end

  // Prefix scan: count leading prefixes, track operand-size toggles
  logic [PosW-1:0] npfx;
  logic            done;
  logic            parity;

  always_comb begin
    npfx   = '0;
    done   = 1'b0;
    parity = 1'b0;
    for (int i = 0; i <= MaxPrefixes; i++) begin
      if (!done) begin
        if (win[i] == x86se_pkg::PfxOpSize || win[i] == x86se_pkg::PfxAddr ||
            win[i] == x86se_pkg::PfxRep) begin
          npfx = PosW'(i + 1);
          if (win[i] == x86se_pkg::PfxOpSize) begin
            parity = ~parity;
          end
        end else begin
          done = 1'b1;
        end
      end
    end
  end

  // Opcode and the six bytes after it
  logic [7:0] op;
  logic [7:0] b [1:6];

  always_comb begin
    op = win[npfx];
    for (int k = 1; k <= 6; k++) begin
      b[k] = win[npfx + PosW'(k)];
    end
  end

  // Classification
  logic        is16;
  logic [4:0]  len_base;
  logic [31:0] imm_sz;
  logic [15:0] seg_sz;
  logic [4:0]  imm_len;

  assign is16     = ~(mode_q ^ parity);
  assign len_base = 5'(npfx) + 5'd1;
  assign imm_sz   = is16 ? {16'h0000, b[2], b[1]} : {b[4], b[3], b[2], b[1]};
  assign seg_sz   = is16 ? {b[4], b[3]} : {b[6], b[5]};
  assign imm_len  = is16 ? 5'd2 : 5'd4;

  always_comb begin
    item_o       = '0;
    item_o.is16  = is16;
    item_o.op_lo = op[3:0];
    item_o.len   = len_base;
    priority if (!done) begin
      item_o.kind = x86se_pkg::KindPfxErr;
      item_o.len  = 5'(npfx);
    end else if (op >= x86se_pkg::OpIncLo && op <= x86se_pkg::OpDecHi) begin
      item_o.kind = x86se_pkg::KindIncDec;
    end else if (op == x86se_pkg::OpNop) begin
      item_o.kind = x86se_pkg::KindNop;
    end else if (op >= x86se_pkg::OpMovLo && op <= x86se_pkg::OpMovHi) begin
      item_o.kind = x86se_pkg::KindMov;
      item_o.imm  = imm_sz;
      item_o.len  = len_base + imm_len;
    end else if (op == x86se_pkg::OpInt3) begin
      item_o.kind = x86se_pkg::KindInt;
      item_o.imm  = {24'h0, x86se_pkg::Int3Vector};
    end else if (op == x86se_pkg::OpInt) begin
      item_o.kind = x86se_pkg::KindInt;
      item_o.imm  = {24'h0, b[1]};
      item_o.len  = len_base + 5'd1;
    end else if (op == x86se_pkg::OpJmpFar) begin
      item_o.kind = x86se_pkg::KindJmpFar;
      item_o.imm  = imm_sz;
      item_o.seg  = seg_sz;
      item_o.len  = len_base + imm_len + 5'd2;
    end else if (op == x86se_pkg::OpJmpShort) begin
      // relative target from the old pc: sign-extended disp plus length
      item_o.kind = x86se_pkg::KindJmpShort;
      item_o.len  = len_base + 5'd1;
      item_o.imm  = {{24{b[1][7]}}, b[1]} + 32'(len_base + 5'd1);
    end else if (op >= x86se_pkg::OpFlagLo && op <= x86se_pkg::OpFlagHi) begin
      item_o.kind = x86se_pkg::KindFlag;
    end else begin
      item_o.kind = x86se_pkg::KindUnimpl;
    end
  end

endmodule

// ===== rtl/x86se_queue.sv =====
// Short FIFO of decoded items between front and back.
module x86se_queue #(
  parameter int unsigned Depth = x86se_pkg::QueueDepthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  x86se_pkg::item_t item_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output x86se_pkg::item_t item_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  x86se_pkg::item_t mem_q [Depth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  // Fill count stays within depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count above depth");

endmodule

// ===== rtl/x86se_execute.sv =====
// Back end: architectural state, instruction execution and result register.
module x86se_execute (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  x86se_pkg::item_t item_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [1:0]       status_o,
  output logic [4:0]       instr_length_o,
  output logic [31:0]      next_pc_o,
  output logic [15:0]      code_segment_o,
  output logic [31:0]      flags_out_o,
  output logic [7:0]       int_vector_o,
  output logic             reg_written_o,
  output logic [2:0]       reg_index_o,
  output logic [31:0]      reg_value_o
);

  // Architectural state
  logic [31:0] regs_q [8];
  logic [31:0] pc_q, pc_d;
  logic [15:0] cs_q, cs_d;
  logic [31:0] flags_q, flags_d;

  // Result register
  logic                out_valid_q;
  x86se_pkg::status_e  status_q, status_d;
  logic [4:0]          len_q;
  logic [7:0]          vector_q, vector_d;
  logic                wr_q, wr_d;
  logic [2:0]          idx_q, idx_d;
  logic [31:0]         val_q, val_d;

  logic        pop;
  logic [2:0]  ridx;
  logic [31:0] old_r, incdec_v, pc_seq, pc_rel, flag_mask;

  assign pop   = valid_i && (!out_valid_q || !out_stall_i);
  assign pop_o = pop;

  // Operand fetch and adders
  assign ridx     = item_i.op_lo[2:0];
  assign old_r    = regs_q[ridx];
  assign incdec_v = item_i.op_lo[3] ? old_r - 32'd1 : old_r + 32'd1;
  assign pc_seq   = pc_q + 32'(item_i.len);
  assign pc_rel   = pc_q + item_i.imm;

  always_comb begin
    flag_mask = '0;
    unique case (item_i.op_lo[2:1])
      x86se_pkg::FlagSelCf: flag_mask[x86se_pkg::FlagCf] = 1'b1;
      x86se_pkg::FlagSelIf: flag_mask[x86se_pkg::FlagIf] = 1'b1;
      default:              flag_mask[x86se_pkg::FlagDf] = 1'b1;
    endcase
  end

  // Execute
  always_comb begin
    pc_d     = pc_q;
    cs_d     = cs_q;
    flags_d  = flags_q;
    status_d = x86se_pkg::StatOk;
    vector_d = '0;
    wr_d     = 1'b0;
    idx_d    = '0;
    val_d    = '0;
    unique case (item_i.kind)
      x86se_pkg::KindIncDec: begin
        wr_d  = 1'b1;
        idx_d = ridx;
        val_d = x86se_pkg::merge(item_i.is16, old_r, incdec_v);
        pc_d  = pc_seq;
      end
      x86se_pkg::KindNop: begin
        pc_d = pc_seq;
      end
      x86se_pkg::KindMov: begin
        wr_d  = 1'b1;
        idx_d = ridx;
        val_d = x86se_pkg::merge(item_i.is16, old_r, item_i.imm);
        pc_d  = pc_seq;
      end
      x86se_pkg::KindInt: begin
        status_d = x86se_pkg::StatSwInt;
        vector_d = item_i.imm[7:0];
        pc_d     = pc_seq;
      end
      x86se_pkg::KindJmpFar: begin
        cs_d = item_i.seg;
        pc_d = x86se_pkg::merge(item_i.is16, pc_q, item_i.imm);
      end
      x86se_pkg::KindJmpShort: begin
        pc_d = x86se_pkg::merge(item_i.is16, pc_seq, pc_rel);
      end
      x86se_pkg::KindFlag: begin
        flags_d = item_i.op_lo[0] ? (flags_q | flag_mask) : (flags_q & ~flag_mask);
        pc_d    = pc_seq;
      end
      x86se_pkg::KindPfxErr: begin
        status_d = x86se_pkg::StatPrefix;
      end
      default: begin
        status_d = x86se_pkg::StatUnimpl;
      end
    endcase
  end

  // State update on each executed item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) begin
        regs_q[i] <= (3'(i) == x86se_pkg::SpIndex) ? x86se_pkg::SpReset : 32'h0;
      end
      pc_q        <= '0;
      cs_q        <= '0;
      flags_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        pc_q    <= pc_d;
        cs_q    <= cs_d;
        flags_q <= flags_d;
        if (wr_d) begin
          regs_q[idx_d] <= val_d;
        end
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (pop) begin
      status_q <= status_d;
      len_q    <= item_i.len;
      vector_q <= vector_d;
      wr_q     <= wr_d;
      idx_q    <= idx_d;
      val_q    <= val_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign instr_length_o = len_q;
  assign next_pc_o      = pc_q;
  assign code_segment_o = cs_q;
  assign flags_out_o    = flags_q;
  assign int_vector_o   = vector_q;
  assign reg_written_o  = wr_q;
  assign reg_index_o    = idx_q;
  assign reg_value_o    = val_q;

  // nop advances pc by exactly its length
  a_nop_pc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && item_i.kind == x86se_pkg::KindNop
    |=> pc_q == $past(pc_q) + 32'($past(item_i.len)))
    else $error("nop pc advance wrong");

  // error items leave pc, cs and flags alone
  a_err_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && (item_i.kind == x86se_pkg::KindUnimpl || item_i.kind == x86se_pkg::KindPfxErr)
    |=> $stable(pc_q) && $stable(cs_q) && $stable(flags_q))
    else $error("error item changed state");

  // a register write is only reported for a normally executed item
  a_wr_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && wr_q |-> status_q == x86se_pkg::StatOk)
    else $error("register write with non-ok status");

endmodule

// ===== rtl/x86_subset_instruction_execute.sv =====
// Top level of the x86 subset execute block: decode front, item queue, execute back.
// An accepted item is written into the queue, then executed into the result register once that
// register is free or the output is not stalled. Throughput: one item per cycle while the output
// is not stalled; the QueueDepth-item queue fills only on output stall.
// Reset (asynchronous, active low): queue empty, no result pending, pc/cs/flags zero,
// registers zero except sp = 0xff0, operand mode 32-bit.
module x86_subset_instruction_execute #(
  parameter int unsigned MaxPrefixes = x86se_pkg::MaxPrefixesDef,
  parameter int unsigned WindowBytes = x86se_pkg::WindowBytesDef,
  parameter int unsigned QueueDepth  = x86se_pkg::QueueDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] instr_bytes_low_i,
  input  logic [63:0] instr_bytes_high_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [4:0]  instr_length_o,
  output logic [31:0] next_pc_o,
  output logic [15:0] code_segment_o,
  output logic [31:0] flags_out_o,
  output logic [7:0]  int_vector_o,
  output logic        reg_written_o,
  output logic [2:0]  reg_index_o,
  output logic [31:0] reg_value_o
);

  x86se_pkg::item_t dec_item, q_item;
  logic             q_full, q_valid, q_pop;

  assign in_stall_o = q_full;

  // Front end
  x86se_decode #(
    .MaxPrefixes (MaxPrefixes),
    .WindowBytes (WindowBytes)
  ) u_decode (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_data_i         (cfg_data_i),
    .instr_bytes_low_i  (instr_bytes_low_i),
    .instr_bytes_high_i (instr_bytes_high_i),
    .item_o             (dec_item)
  );

  // Decoupling queue
  x86se_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_valid_i),
    .item_i  (dec_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  // Back end
  x86se_execute u_execute (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (q_valid),
    .item_i         (q_item),
    .pop_o          (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .instr_length_o (instr_length_o),
    .next_pc_o      (next_pc_o),
    .code_segment_o (code_segment_o),
    .flags_out_o    (flags_out_o),
    .int_vector_o   (int_vector_o),
    .reg_written_o  (reg_written_o),
    .reg_index_o    (reg_index_o),
    .reg_value_o    (reg_value_o)
  );

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the x86 subset execute block.

// One retired instruction as reported on the result channel
typedef struct {
  logic [1:0]  status;
  logic [4:0]  len;
  logic [31:0] pc;
  logic [15:0] cs;
  logic [31:0] flags;
  logic [7:0]  vec;
  logic        wr;
  logic [2:0]  idx;
  logic [31:0] val;
} retire_t;

// Architectural state mirror plus the queue of retirements still to arrive
class exec_checker;
  logic [31:0] gpr[8];
  logic [31:0] pc;
  logic [15:0] cs;
  logic [31:0] flags;
  logic        mode32;
  retire_t     pending_retires[$];
  int          errors;

  function new();
    foreach (gpr[i]) gpr[i] = '0;
    gpr[x86se_pkg::SpIndex] = x86se_pkg::SpReset;
    pc     = '0;
    cs     = '0;
    flags  = '0;
    mode32 = 1'b1;
    errors = 0;
  endfunction

  function int pending();
    return pending_retires.size();
  endfunction

  function logic [7:0] win_byte(logic [127:0] w, int i);
    return (i >= x86se_pkg::WindowBytesDef) ? 8'h00 : w[i*8 +: 8];
  endfunction

  function logic [31:0] win_imm(logic [127:0] w, int p, int nb);
    logic [31:0] v;
    v = '0;
    for (int k = 0; k < nb; k++) v[k*8 +: 8] = win_byte(w, p + k);
    return v;
  endfunction

  // 16-bit size: new low half, old high half
  function logic [31:0] keep_upper(logic is16, logic [31:0] oldv, logic [31:0] newv);
    return is16 ? {oldv[31:16], newv[15:0]} : newv;
  endfunction

  // Execute one window against the mirror and queue the retirement
  function void note_window(logic [127:0] w);
    retire_t     e;
    logic        is16;
    logic        pfx_err;
    int          pos;
    int          npfx;
    int          nb;
    logic [7:0]  b;
    logic [7:0]  op;
    logic [2:0]  r;
    logic [31:0] v;
    logic [31:0] npc;
    logic [31:0] mask;
    is16    = !mode32;
    pos     = 0;
    npfx    = 0;
    pfx_err = 1'b0;
    e.status = x86se_pkg::StatOk;
    e.vec = '0;
    e.wr  = 1'b0;
    e.idx = '0;
    e.val = '0;
    // prefix scan
    forever begin
      b = win_byte(w, pos);
      if (b == x86se_pkg::PfxOpSize) is16 = !is16;
      else if (b != x86se_pkg::PfxAddr && b != x86se_pkg::PfxRep) break;
      pos++;
      npfx++;
      if (npfx > x86se_pkg::MaxPrefixesDef) begin
        pfx_err = 1'b1;
        break;
      end
    end
    if (pfx_err) begin
      e.status = x86se_pkg::StatPrefix;
      e.len = 5'(pos);
    end else begin
      op = win_byte(w, pos);
      pos++;
      e.len = 5'(pos);
      r = op[2:0];
      nb = is16 ? 2 : 4;
      if (op >= x86se_pkg::OpIncLo && op <= x86se_pkg::OpDecHi) begin
        v = op[3] ? gpr[r] - 32'd1 : gpr[r] + 32'd1;
        gpr[r] = keep_upper(is16, gpr[r], v);
        e.wr = 1'b1; e.idx = r; e.val = gpr[r];
        pc = pc + 32'(e.len);
      end else if (op == x86se_pkg::OpNop) begin
        pc = pc + 32'(e.len);
      end else if (op >= x86se_pkg::OpMovLo && op <= x86se_pkg::OpMovHi) begin
        v = win_imm(w, pos, nb);
        e.len = e.len + 5'(nb);
        gpr[r] = keep_upper(is16, gpr[r], v);
        e.wr = 1'b1; e.idx = r; e.val = gpr[r];
        pc = pc + 32'(e.len);
      end else if (op == x86se_pkg::OpInt3) begin
        e.status = x86se_pkg::StatSwInt;
        e.vec = x86se_pkg::Int3Vector;
        pc = pc + 32'(e.len);
      end else if (op == x86se_pkg::OpInt) begin
        e.vec = win_byte(w, pos);
        e.len = e.len + 5'd1;
        e.status = x86se_pkg::StatSwInt;
        pc = pc + 32'(e.len);
      end else if (op == x86se_pkg::OpJmpFar) begin
        v = win_imm(w, pos, nb);
        cs = 16'(win_imm(w, pos + nb, 2));
        e.len = e.len + 5'(nb + 2);
        pc = keep_upper(is16, pc, v);
      end else if (op == x86se_pkg::OpJmpShort) begin
        b = win_byte(w, pos);
        v = {{24{b[7]}}, b};
        e.len = e.len + 5'd1;
        npc = pc + 32'(e.len);
        pc = keep_upper(is16, npc, npc + v);
      end else if (op >= x86se_pkg::OpFlagLo && op <= x86se_pkg::OpFlagHi) begin
        mask = '0;
        if (op[2:1] == x86se_pkg::FlagSelCf) mask[x86se_pkg::FlagCf] = 1'b1;
        else if (op[2:1] == x86se_pkg::FlagSelIf) mask[x86se_pkg::FlagIf] = 1'b1;
        else mask[x86se_pkg::FlagDf] = 1'b1;
        flags = op[0] ? (flags | mask) : (flags & ~mask);
        pc = pc + 32'(e.len);
      end else begin
        e.status = x86se_pkg::StatUnimpl;
      end
    end
    e.pc    = pc;
    e.cs    = cs;
    e.flags = flags;
    pending_retires.push_back(e);
  endfunction

  function void cmp(string fld, logic [31:0] exp_v, logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, fld, exp_v, got_v);
      errors++;
    end
  endfunction

  // Compare one accepted result with the oldest queued retirement
  function void check_retire(retire_t got);
    retire_t e;
    if (pending_retires.size() == 0) begin
      $display("%0t: unexpected result: expected none, got pc %h", $time, got.pc);
      errors++;
      return;
    end
    e = pending_retires.pop_front();
    cmp("status", e.status, got.status);
    cmp("instr_length", e.len, got.len);
    cmp("next_pc", e.pc, got.pc);
    cmp("code_segment", e.cs, got.cs);
    cmp("flags_out", e.flags, got.flags);
    cmp("int_vector", e.vec, got.vec);
    cmp("reg_written", e.wr, got.wr);
    cmp("reg_index", e.idx, got.idx);
    cmp("reg_value", e.val, got.val);
  endfunction
endclass

module tb;
  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned ItemsPerPhase = 320;
  localparam int unsigned LongHold = 400;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [0:0]  cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [63:0] instr_bytes_low_i;
  logic [63:0] instr_bytes_high_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  status_o;
  logic [4:0]  instr_length_o;
  logic [31:0] next_pc_o;
  logic [15:0] code_segment_o;
  logic [31:0] flags_out_o;
  logic [7:0]  int_vector_o;
  logic        reg_written_o;
  logic [2:0]  reg_index_o;
  logic [31:0] reg_value_o;

  exec_checker chk;
  bit          hold_req;
  bit          snd_burst;
  int unsigned cycle_cnt;

  x86_subset_instruction_execute dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .instr_bytes_low_i  (instr_bytes_low_i),
    .instr_bytes_high_i (instr_bytes_high_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .status_o           (status_o),
    .instr_length_o     (instr_length_o),
    .next_pc_o          (next_pc_o),
    .code_segment_o     (code_segment_o),
    .flags_out_o        (flags_out_o),
    .int_vector_o       (int_vector_o),
    .reg_written_o      (reg_written_o),
    .reg_index_o        (reg_index_o),
    .reg_value_o        (reg_value_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // Idle cycles before an item; zero during burst stretches
  function automatic int draw_gap(bit burst);
    return burst ? 0 : $urandom_range(0, 19);
  endfunction

  // Mostly well-formed windows: prefixes, a real opcode, random operands
  function automatic logic [127:0] gen_window();
    logic [127:0] w;
    int           sel;
    int           npfx;
    logic [7:0]   op;
    w = {$urandom, $urandom, $urandom, $urandom};
    sel = $urandom_range(0, 99);
    if (sel < 10) return w;
    if (sel < 16) npfx = $urandom_range(5, 8);
    else if ($urandom_range(0, 1) != 0) npfx = 0;
    else npfx = $urandom_range(1, 4);
    for (int k = 0; k < npfx; k++) begin
      case ($urandom_range(0, 2))
        0:       w[k*8 +: 8] = x86se_pkg::PfxOpSize;
        1:       w[k*8 +: 8] = x86se_pkg::PfxAddr;
        default: w[k*8 +: 8] = x86se_pkg::PfxRep;
      endcase
    end
    if (npfx > x86se_pkg::MaxPrefixesDef) return w;
    case ($urandom_range(0, 9))
      0:       op = 8'(x86se_pkg::OpIncLo + $urandom_range(0, 15));
      1:       op = x86se_pkg::OpNop;
      2, 3:    op = 8'(x86se_pkg::OpMovLo + $urandom_range(0, 7));
      4:       op = x86se_pkg::OpInt3;
      5:       op = x86se_pkg::OpInt;
      6:       op = x86se_pkg::OpJmpFar;
      7:       op = x86se_pkg::OpJmpShort;
      8:       op = 8'(x86se_pkg::OpFlagLo + $urandom_range(0, 5));
      default: op = 8'($urandom_range(0, 255));
    endcase
    w[npfx*8 +: 8] = op;
    // occasional all-zero / all-one operands to hit wrap cases
    if ($urandom_range(0, 7) == 0)
      w[(npfx+1)*8 +: 32] = ($urandom_range(0, 1) != 0) ? 32'hffff_ffff : 32'h0;
    return w;
  endfunction

  // Offer one window and hold it until accepted
  task automatic send_item(input logic [127:0] w);
    int gap;
    if ($urandom_range(0, 49) == 0) snd_burst = !snd_burst;
    gap = draw_gap(snd_burst);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    instr_bytes_low_i = w[63:0];
    instr_bytes_high_i = w[127:64];
    do @(posedge clk_i); while (in_stall_o);
    chk.note_window(w);
  endtask

  // Stop offering and wait for all retirements plus pipeline slack
  task automatic drain_block();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (chk.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_operand_mode(input logic m);
    drain_block();
    cfg_we_i = 1'b1;
    cfg_data_i = m;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    chk.mode32 = m;
  endtask

  // Result side: random stall per item, one long hold-off on request
  initial begin
    int      hold;
    bit      rcv_burst;
    retire_t got;
    out_stall_i = 1'b1;
    rcv_burst = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if ($urandom_range(0, 49) == 0) rcv_burst = !rcv_burst;
      hold = draw_gap(rcv_burst);
      if (hold_req) begin
        hold = LongHold;
        hold_req = 1'b0;
      end
      @(negedge clk_i);
      if (hold > 0) begin
        out_stall_i = 1'b1;
        repeat (hold - 1) @(negedge clk_i);
        @(negedge clk_i);
      end
      out_stall_i = 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      got.status = status_o;
      got.len    = instr_length_o;
      got.pc     = next_pc_o;
      got.cs     = code_segment_o;
      got.flags  = flags_out_o;
      got.vec    = int_vector_o;
      got.wr     = reg_written_o;
      got.idx    = reg_index_o;
      got.val    = reg_value_o;
      chk.check_retire(got);
    end
  end

  // Stimulus
  initial begin
    cfg_we_i = 1'b0;
    cfg_data_i = 1'b0;
    in_valid_i = 1'b0;
    instr_bytes_low_i = '0;
    instr_bytes_high_i = '0;
    hold_req = 1'b0;
    snd_burst = 1'b0;
    chk = new();
    rst_ni = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed, 32-bit default size
    write_operand_mode(1'b1);
    send_item(128'h90);                        // nop
    send_item(128'h40);                        // inc eax
    send_item(128'h48);                        // dec eax
    send_item(128'h48);                        // dec eax, wraps below zero
    send_item(128'h4c);                        // dec esp
    send_item(128'h47);                        // inc edi
    send_item(128'hffff_ffff_ffff_ffff_ffff_ffff_ffbf); // mov edi, all ones
    send_item(128'h1234b866);                  // 16-bit mov via prefix
    send_item(128'habcd12345678ea);            // far jmp
    send_item(128'h0001ffffea66);              // 16-bit far jmp keeps pc upper half
    send_item(128'h7feb);                      // short jmp forward max
    send_item(128'h80eb);                      // short jmp back max
    send_item(128'hf9);                        // stc
    send_item(128'hfb);                        // sti
    send_item(128'hfd);                        // std
    send_item(128'hf8);                        // clc
    send_item(128'hfa);                        // cli
    send_item(128'hfc);                        // cld
    send_item(128'hcc);                        // int3
    send_item(128'hffcd);                      // int ff
    send_item(128'h9066f36766);                // four prefixes, then nop
    send_item(128'h66f3676666);                // fifth prefix is an error
    send_item(128'h0f);                        // unimplemented opcode
    send_item({128{1'b1}});                    // all ones: unimplemented
    send_item(128'hfffffffeea);                // far jmp near top of pc range
    send_item(128'h00000000b8);                // mov, pc wraps

    // directed, 16-bit default size
    write_operand_mode(1'b0);
    send_item(128'hffffb8);                    // mov ax, ffff
    send_item(128'h40);                        // inc ax, low half wraps
    send_item(128'h12345678b866);              // prefix restores 32-bit mov
    send_item(128'h0000fff0ea);                // far jmp, low half only
    send_item(128'h7feb);                      // short jmp wraps in low half

    // random phases, alternating default size
    for (int ph = 0; ph < 6; ph++) begin
      write_operand_mode(ph[0]);
      if (ph == 3) hold_req = 1'b1;
      repeat (ItemsPerPhase) send_item(gen_window());
    end

    drain_block();
    repeat (8) @(posedge clk_i);
    if (chk.errors == 0 && chk.pending() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
